// ===== rtl/core/bcm_pkg.sv =====
package bcm_pkg;

    localparam int MAX_CELLS_DEFAULT = 16;
    localparam int CELL_INDEX_LIMIT  = 16;

    localparam int VOLT_W   = 13;
    localparam int TEMP_W   = 12;
    localparam int COUNT_W  = 5;
    localparam int INDEX_W  = 4;
    localparam int SUM_W    = 17;
    localparam int STATUS_W = 3;
    localparam int SOC_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int DIV_NUM_W = 20;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_VOLTAGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_VOLTAGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_TEMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_EMPTY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_FULL      = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVER_VOLTAGE  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDER_VOLTAGE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVER_TEMP     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_UNDER_TEMP    = 3'd4;

    localparam logic [COUNT_W-1:0]       RST_CELL_COUNT    = 5'd8;
    localparam logic [VOLT_W-1:0]        RST_OVER_VOLTAGE  = 13'd4200;
    localparam logic [VOLT_W-1:0]        RST_UNDER_VOLTAGE = 13'd3000;
    localparam logic signed [TEMP_W-1:0] RST_OVER_TEMP     = 12'sd600;
    localparam logic signed [TEMP_W-1:0] RST_UNDER_TEMP    = -12'sd400;
    localparam logic [VOLT_W-1:0]        RST_BALANCE       = 13'd4150;
    localparam logic [VOLT_W-1:0]        RST_SOC_EMPTY     = 13'd3200;
    localparam logic [VOLT_W-1:0]        RST_SOC_FULL      = 13'd4200;

    localparam logic [VOLT_W-1:0] VOLT_MIN_INIT = 13'h1FFF;
    localparam logic [SOC_W-1:0]  SOC_FULL_PERCENT = 7'd100;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_sel_soc;
        logic div_step;
        logic avg_load;
        logic mul_load;
        logic soc_fix;
        logic soc_load;
        logic emit;
    } bcm_cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic soc_clamp;
        logic out_free;
    } bcm_status_t;

endpackage

// ===== rtl/core/bcm_ctrl.sv =====
module bcm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bcm_pkg::bcm_status_t status,
    output bcm_pkg::bcm_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b000_0001,
        ST_EMIT      = 7'b000_0010,
        ST_AVG_START = 7'b000_0100,
        ST_AVG_DIV   = 7'b000_1000,
        ST_CHECK     = 7'b001_0000,
        ST_SOC_START = 7'b010_0000,
        ST_SOC_DIV   = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.last ? ST_AVG_START : ST_EMIT;
                end
            end
            ST_AVG_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_AVG_DIV;
            end
            ST_AVG_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.avg_load = 1'b1;
                    state_next   = ST_CHECK;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (status.soc_clamp)
                begin
                    cmd.soc_fix = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = ST_SOC_START;
                end
            end
            ST_SOC_START:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_soc = 1'b1;
                state_next      = ST_SOC_DIV;
            end
            ST_SOC_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.soc_load = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/bcm_dp.sv =====
module bcm_dp #(
    parameter int MAX_CELLS = bcm_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [bcm_pkg::VOLT_W-1:0]            cell_voltage,
    input  logic signed [bcm_pkg::TEMP_W-1:0]     cell_temp,
    input  bcm_pkg::bcm_cmd_t                     cmd,
    output bcm_pkg::bcm_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bcm_pkg::INDEX_W-1:0]           cell_index,
    output logic                                  balance_request,
    output logic                                  scan_done,
    output logic [bcm_pkg::STATUS_W-1:0]          pack_status,
    output logic [bcm_pkg::SOC_W-1:0]             state_of_charge,
    output logic [bcm_pkg::VOLT_W-1:0]            min_cell_voltage,
    output logic [bcm_pkg::VOLT_W-1:0]            max_cell_voltage
);

    localparam int VW = bcm_pkg::VOLT_W;
    localparam int TW = bcm_pkg::TEMP_W;
    localparam int CW = bcm_pkg::COUNT_W;
    localparam int IW = bcm_pkg::INDEX_W;
    localparam int SW = bcm_pkg::SUM_W;
    localparam int NW = bcm_pkg::DIV_NUM_W;
    localparam int CELL_CAP = (MAX_CELLS < bcm_pkg::CELL_INDEX_LIMIT) ?
                              MAX_CELLS : bcm_pkg::CELL_INDEX_LIMIT;
    localparam logic [CW-1:0] CellCap = CW'(CELL_CAP);

    logic [CW-1:0]        cell_count_reg;
    logic [VW-1:0]        over_voltage_reg;
    logic [VW-1:0]        under_voltage_reg;
    logic signed [TW-1:0] over_temp_reg;
    logic signed [TW-1:0] under_temp_reg;
    logic [VW-1:0]        balance_reg;
    logic [VW-1:0]        soc_empty_reg;
    logic [VW-1:0]        soc_full_reg;

    logic [IW-1:0]                  cell_counter_reg, cell_counter_next;
    logic [SW-1:0]                  voltage_sum_reg, voltage_sum_next;
    logic [VW-1:0]                  running_min_reg, running_min_next;
    logic [VW-1:0]                  running_max_reg, running_max_next;
    logic [bcm_pkg::STATUS_W-1:0]   first_fault_reg, first_fault_next;

    logic [IW-1:0] item_index_reg;
    logic          item_balance_reg;
    logic          item_last_reg;

    logic [VW-1:0]              div_rem_reg, div_rem_next;
    logic [NW-1:0]              div_quo_reg, div_quo_next;
    logic [VW-1:0]              div_den_reg, div_den_next;
    logic [bcm_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [SW-1:0]              avg_reg;
    logic [NW-1:0]              num_reg;
    logic [bcm_pkg::SOC_W-1:0]  soc_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [IW-1:0]               out_index_reg;
    logic                        out_balance_reg;
    logic                        out_done_reg;
    logic [bcm_pkg::STATUS_W-1:0] out_status_reg;
    logic [bcm_pkg::SOC_W-1:0]   out_soc_reg;
    logic [VW-1:0]               out_min_reg;
    logic [VW-1:0]               out_max_reg;

    logic [CW-1:0] cells_raw;
    logic [CW-1:0] cells;
    logic          last_now;
    logic [VW:0]   rem_shift;
    logic [VW:0]   rem_sub;
    logic          fits;
    logic [VW-1:0] soc_diff;
    logic          soc_low;
    logic          soc_high;

    always_comb
    begin
        cells_raw = (cell_count_reg == '0) ? CW'(1) : cell_count_reg;
        cells     = (cells_raw > CellCap) ? CellCap : cells_raw;
        last_now  = ({1'b0, cell_counter_reg} + CW'(1)) >= cells;
    end

    always_comb
    begin
        cell_counter_next = cell_counter_reg;
        voltage_sum_next  = voltage_sum_reg;
        running_min_next  = running_min_reg;
        running_max_next  = running_max_reg;
        first_fault_next  = first_fault_reg;
        if (cmd.emit && item_last_reg)
        begin
            cell_counter_next = '0;
            voltage_sum_next  = '0;
            running_min_next  = bcm_pkg::VOLT_MIN_INIT;
            running_max_next  = '0;
            first_fault_next  = bcm_pkg::STATUS_OK;
        end
        else if (cmd.capture)
        begin
            voltage_sum_next = voltage_sum_reg + SW'(cell_voltage);
            if (cell_voltage < running_min_reg)
            begin
                running_min_next = cell_voltage;
            end
            if (cell_voltage > running_max_reg)
            begin
                running_max_next = cell_voltage;
            end
            if (first_fault_reg == bcm_pkg::STATUS_OK)
            begin
                if (cell_voltage > over_voltage_reg)
                begin
                    first_fault_next = bcm_pkg::STATUS_OVER_VOLTAGE;
                end
                else if (cell_voltage < under_voltage_reg)
                begin
                    first_fault_next = bcm_pkg::STATUS_UNDER_VOLTAGE;
                end
                else if (cell_temp > over_temp_reg)
                begin
                    first_fault_next = bcm_pkg::STATUS_OVER_TEMP;
                end
                else if (cell_temp < under_temp_reg)
                begin
                    first_fault_next = bcm_pkg::STATUS_UNDER_TEMP;
                end
            end
            if (!last_now)
            begin
                cell_counter_next = cell_counter_reg + IW'(1);
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb
    begin
        rem_shift    = {div_rem_reg, div_quo_reg[NW-1]};
        rem_sub      = rem_shift - {1'b0, div_den_reg};
        fits         = rem_shift >= {1'b0, div_den_reg};
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start)
        begin
            div_rem_next = '0;
            div_cnt_next = bcm_pkg::DIV_STEPS;
            if (cmd.div_sel_soc)
            begin
                div_quo_next = num_reg;
                div_den_next = soc_full_reg - soc_empty_reg;
            end
            else
            begin
                div_quo_next = NW'(voltage_sum_reg);
                div_den_next = VW'(cells);
            end
        end
        else if (cmd.div_step)
        begin
            div_rem_next = fits ? rem_sub[VW-1:0] : rem_shift[VW-1:0];
            div_quo_next = {div_quo_reg[NW-2:0], fits};
            div_cnt_next = div_cnt_reg - bcm_pkg::DIV_CNT_W'(1);
        end
    end

    always_comb
    begin
        soc_low  = avg_reg <= SW'(soc_empty_reg);
        soc_high = avg_reg >= SW'(soc_full_reg);
        soc_diff = avg_reg[VW-1:0] - soc_empty_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        status.last      = last_now;
        status.div_done  = (div_cnt_reg == '0);
        status.soc_clamp = soc_low || soc_high;
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg    <= bcm_pkg::RST_CELL_COUNT;
            over_voltage_reg  <= bcm_pkg::RST_OVER_VOLTAGE;
            under_voltage_reg <= bcm_pkg::RST_UNDER_VOLTAGE;
            over_temp_reg     <= bcm_pkg::RST_OVER_TEMP;
            under_temp_reg    <= bcm_pkg::RST_UNDER_TEMP;
            balance_reg       <= bcm_pkg::RST_BALANCE;
            soc_empty_reg     <= bcm_pkg::RST_SOC_EMPTY;
            soc_full_reg      <= bcm_pkg::RST_SOC_FULL;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                bcm_pkg::CFG_CELL_COUNT:    cell_count_reg    <= cfg_data[CW-1:0];
                bcm_pkg::CFG_OVER_VOLTAGE:  over_voltage_reg  <= cfg_data[VW-1:0];
                bcm_pkg::CFG_UNDER_VOLTAGE: under_voltage_reg <= cfg_data[VW-1:0];
                bcm_pkg::CFG_OVER_TEMP:     over_temp_reg     <= cfg_data[TW-1:0];
                bcm_pkg::CFG_UNDER_TEMP:    under_temp_reg    <= cfg_data[TW-1:0];
                bcm_pkg::CFG_BALANCE:       balance_reg       <= cfg_data[VW-1:0];
                bcm_pkg::CFG_SOC_EMPTY:     soc_empty_reg     <= cfg_data[VW-1:0];
                bcm_pkg::CFG_SOC_FULL:      soc_full_reg      <= cfg_data[VW-1:0];
                default:                    cell_count_reg    <= cell_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_counter_reg <= '0;
            voltage_sum_reg  <= '0;
            running_min_reg  <= bcm_pkg::VOLT_MIN_INIT;
            running_max_reg  <= '0;
            first_fault_reg  <= bcm_pkg::STATUS_OK;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cell_counter_reg <= cell_counter_next;
            voltage_sum_reg  <= voltage_sum_next;
            running_min_reg  <= running_min_next;
            running_max_reg  <= running_max_next;
            first_fault_reg  <= first_fault_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        if (cmd.capture)
        begin
            item_index_reg   <= cell_counter_reg;
            item_balance_reg <= cell_voltage > balance_reg;
            item_last_reg    <= last_now;
        end
        if (cmd.avg_load)
        begin
            avg_reg <= div_quo_reg[SW-1:0];
        end
        if (cmd.mul_load)
        begin
            num_reg <= NW'(soc_diff) * NW'(bcm_pkg::SOC_FULL_PERCENT);
        end
        if (cmd.soc_fix)
        begin
            soc_reg <= soc_low ? '0 : bcm_pkg::SOC_FULL_PERCENT;
        end
        else if (cmd.soc_load)
        begin
            soc_reg <= div_quo_reg[bcm_pkg::SOC_W-1:0];
        end
        if (cmd.emit)
        begin
            out_index_reg   <= item_index_reg;
            out_balance_reg <= item_balance_reg;
            out_done_reg    <= item_last_reg;
            out_status_reg  <= item_last_reg ? first_fault_reg : bcm_pkg::STATUS_OK;
            out_soc_reg     <= item_last_reg ? soc_reg : '0;
            out_min_reg     <= item_last_reg ? running_min_reg : '0;
            out_max_reg     <= item_last_reg ? running_max_reg : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign cell_index       = out_index_reg;
    assign balance_request  = out_balance_reg;
    assign scan_done        = out_done_reg;
    assign pack_status      = out_status_reg;
    assign state_of_charge  = out_soc_reg;
    assign min_cell_voltage = out_min_reg;
    assign max_cell_voltage = out_max_reg;

endmodule

// ===== rtl/core/battery_cell_monitor_top.sv =====
// Battery cell monitor: one word per cell sample (voltage in mV, temperature in tenths of a
// degree) gives one result word with the cell's scan position and a balance request. The last
// cell of a scan also carries the first fault, the minimum and maximum voltage and the state of
// charge. A cell that is not the last of its scan goes from acceptance to the emit state and
// reaches the result register once that register is free; the next sample is accepted only
// after the controller has returned to idle. The last cell first passes through the shared
// restoring divider, which forms a 20-bit quotient for the average voltage and then another
// for the charge percentage. When the average lies at or outside the empty and full limits,
// the second division is skipped and the percentage is clamped to 0 or 100. A new sample is
// accepted while the previous result still waits in the output register, and its own result
// then waits until that register is free.
module battery_cell_monitor_top #(
    parameter int MAX_CELLS = bcm_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bcm_pkg::VOLT_W-1:0]        cell_voltage,
    input  logic signed [bcm_pkg::TEMP_W-1:0] cell_temp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcm_pkg::INDEX_W-1:0]       cell_index,
    output logic                              balance_request,
    output logic                              scan_done,
    output logic [bcm_pkg::STATUS_W-1:0]      pack_status,
    output logic [bcm_pkg::SOC_W-1:0]         state_of_charge,
    output logic [bcm_pkg::VOLT_W-1:0]        min_cell_voltage,
    output logic [bcm_pkg::VOLT_W-1:0]        max_cell_voltage
);

    bcm_pkg::bcm_cmd_t    cmd;
    bcm_pkg::bcm_status_t status;

    bcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcm_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cell_voltage     (cell_voltage),
        .cell_temp        (cell_temp),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .cell_index       (cell_index),
        .balance_request  (balance_request),
        .scan_done        (scan_done),
        .pack_status      (pack_status),
        .state_of_charge  (state_of_charge),
        .min_cell_voltage (min_cell_voltage),
        .max_cell_voltage (max_cell_voltage)
    );

endmodule
